[hdl/aarm_pkg.sv]
// shared types, constants and helper functions for the axis-angle rotation block
`default_nettype none
package aarm_pkg;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [30:0] angle_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec3_type;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int CRD_STEPS  = 30;

   // normalize: abs, max, shift search, shift, squares, sum, sqrt, numerator, divide, sign
   localparam int NRM_LAT   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int CRD_LAT   = CRD_STEPS + 2;
   localparam int MTX_LAT   = 7;
   localparam int TOTAL_LAT = NRM_LAT + CRD_LAT + MTX_LAT;

   localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
   localparam logic signed [35:0] CRD_GAIN    = 36'sd652032874;
   localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   localparam logic signed [71:0] HALF_LSB72  = 72'sd536870912;

   // shift-subtract long division, evaluated at elaboration only
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-idx) in Q30, evaluated at elaboration only
   function automatic longint atan_q30(input int unsigned idx);
      longint sum;
      longint unsigned term;
      int unsigned e;
      sum = 0;
      if (idx == 0) begin
         return 64'sd843314857;
      end
      for (int unsigned k = 0; k < 64; k++) begin
         e = idx * (2 * k + 1);
         if (e <= 62) begin
            term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
            if (k[0]) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
      end
      return (sum + (64'sd1 << 31)) >>> 32;
   endfunction

   // q30 product rounded half up
   function automatic logic signed [35:0] mul30(input logic signed [35:0] a,
                                                input logic signed [35:0] b);
      logic signed [71:0] pr;
      pr = a * b;
      pr = pr + HALF_LSB72;
      return 36'(pr >>> 30);
   endfunction

   function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
      if (v > ONE_Q30) begin
         return 32'(ONE_Q30);
      end else if (v < -ONE_Q30) begin
         return 32'(-ONE_Q30);
      end
      return 32'(v);
   endfunction

endpackage
`default_nettype wire

[hdl/aarm_norm.sv]
// direction normalizer: abs, scaling, squares, pipelined sqrt and dividers
`default_nettype none
module aarm_norm #(
   parameter int TAG_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  aarm_pkg::vec3_type     in_dir,
   input  logic [TAG_W-1:0]       in_tag,
   output logic                   out_valid,
   output aarm_pkg::vec3_type     out_unit,
   output logic                   out_zero,
   output logic [TAG_W-1:0]       out_tag
);
   import aarm_pkg::*;

   localparam int SIDE_W = TAG_W + 4;

   logic [NRM_LAT-1:0] vld_ff;
   logic [SIDE_W-1:0]  side_ff [NRM_LAT];
   logic [SIDE_W-1:0]  side_in;

   logic signed [31:0] dir_c [3];
   logic [31:0] mag1_ff [3];
   logic [31:0] mag2_ff [3];
   logic [31:0] mag3_ff [3];
   logic [31:0] mag4_ff [3];
   logic [31:0] mag5_ff [3];
   logic [31:0] mag6_ff [3];
   logic [31:0] mx2_ff;
   logic [4:0]  sh3_ff;
   logic [4:0]  sh_in;
   logic [63:0] sq5_ff [3];
   logic [63:0] len6_ff;

   logic [63:0] srem_ff [SQRT_STEPS];
   logic [63:0] sres_ff [SQRT_STEPS];
   logic [31:0] smag_ff [SQRT_STEPS][3];

   logic [63:0] num_ff [3];
   logic [31:0] root_ff;

   logic [63:0] drem_ff [DIV_STEPS][3];
   logic [30:0] dquo_ff [DIV_STEPS][3];
   logic [31:0] droot_ff [DIV_STEPS];

   logic signed [31:0] unit_ff [3];

   assign dir_c[0] = in_dir.x;
   assign dir_c[1] = in_dir.y;
   assign dir_c[2] = in_dir.z;

   // side data: signs, zero flag, tag
   always_comb begin
      side_in = {dir_c[2][31], dir_c[1][31], dir_c[0][31],
                 (dir_c[0] == '0) && (dir_c[1] == '0) && (dir_c[2] == '0), in_tag};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NRM_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < NRM_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // leading one search: shift so the largest magnitude reaches bit 30
   always_comb begin
      sh_in = '0;
      for (int b = 0; b < 30; b++) begin
         if (mx2_ff[b]) begin
            sh_in = 5'(30 - b);
         end
      end
      if (mx2_ff[31] || mx2_ff[30]) begin
         sh_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         mag1_ff[j] <= dir_c[j][31] ? 32'(-dir_c[j]) : 32'(dir_c[j]);
         mag2_ff[j] <= mag1_ff[j];
         mag3_ff[j] <= mag2_ff[j];
         mag4_ff[j] <= mag3_ff[j] << sh3_ff;
         mag5_ff[j] <= mag4_ff[j];
         mag6_ff[j] <= mag5_ff[j];
         sq5_ff[j]  <= 64'(mag4_ff[j]) * 64'(mag4_ff[j]);
      end
      mx2_ff <= (mag1_ff[0] >= mag1_ff[1] && mag1_ff[0] >= mag1_ff[2]) ? mag1_ff[0] :
                (mag1_ff[1] >= mag1_ff[2]) ? mag1_ff[1] : mag1_ff[2];
      sh3_ff  <= sh_in;
      len6_ff <= sq5_ff[0] + sq5_ff[1] + sq5_ff[2];
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] rem_p;
      logic [63:0] res_p;
      logic [64:0] trial;
      always_comb begin
         rem_p = (k == 0) ? len6_ff : srem_ff[(k == 0) ? 0 : k - 1];
         res_p = (k == 0) ? 64'd0 : sres_ff[(k == 0) ? 0 : k - 1];
         trial = {1'b0, res_p} + {1'b0, BIT};
      end
      always_ff @(posedge clock) begin
         if ({1'b0, rem_p} >= trial) begin
            srem_ff[k] <= rem_p - trial[63:0];
            sres_ff[k] <= (res_p >> 1) + BIT;
         end else begin
            srem_ff[k] <= rem_p;
            sres_ff[k] <= res_p >> 1;
         end
         for (int j = 0; j < 3; j++) begin
            smag_ff[k][j] <= (k == 0) ? mag6_ff[j] : smag_ff[(k == 0) ? 0 : k - 1][j];
         end
      end
   end

   // rounded numerator: mag * 2^30 + root / 2
   always_ff @(posedge clock) begin
      root_ff <= sres_ff[SQRT_STEPS-1][31:0];
      for (int j = 0; j < 3; j++) begin
         num_ff[j] <= (64'(smag_ff[SQRT_STEPS-1][j]) << 30)
                      + 64'(sres_ff[SQRT_STEPS-1][31:1]);
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      localparam int B = DIV_STEPS - 1 - s;
      logic [31:0] root_p;
      logic [63:0] dvs;
      always_comb begin
         root_p = (s == 0) ? root_ff : droot_ff[(s == 0) ? 0 : s - 1];
         dvs    = 64'(root_p) << B;
      end
      always_ff @(posedge clock) begin
         droot_ff[s] <= root_p;
         for (int j = 0; j < 3; j++) begin
            logic [63:0] rp;
            logic [30:0] qp;
            rp = (s == 0) ? num_ff[j] : drem_ff[(s == 0) ? 0 : s - 1][j];
            qp = (s == 0) ? 31'd0 : dquo_ff[(s == 0) ? 0 : s - 1][j];
            if (rp >= dvs) begin
               drem_ff[s][j] <= rp - dvs;
               dquo_ff[s][j] <= qp | (31'd1 << B);
            end else begin
               drem_ff[s][j] <= rp;
               dquo_ff[s][j] <= qp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (side_ff[NRM_LAT-2][TAG_W+1+j]) begin
            unit_ff[j] <= -$signed({1'b0, dquo_ff[DIV_STEPS-1][j]});
         end else begin
            unit_ff[j] <= $signed({1'b0, dquo_ff[DIV_STEPS-1][j]});
         end
      end
   end

   assign out_valid  = vld_ff[NRM_LAT-1];
   assign out_unit.x = unit_ff[0];
   assign out_unit.y = unit_ff[1];
   assign out_unit.z = unit_ff[2];
   assign out_zero   = side_ff[NRM_LAT-1][TAG_W];
   assign out_tag    = side_ff[NRM_LAT-1][TAG_W-1:0];

endmodule
`default_nettype wire

[hdl/aarm_cordic.sv]
// angle fold and pipelined rotation-mode cordic for cosine and sine
`default_nettype none
module aarm_cordic #(
   parameter int TAG_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  aarm_pkg::angle_type    in_angle,
   input  logic [TAG_W-1:0]       in_tag,
   output logic                   out_valid,
   output aarm_pkg::coord_type    out_cos,
   output aarm_pkg::coord_type    out_sin,
   output logic [TAG_W-1:0]       out_tag
);
   import aarm_pkg::*;

   logic [CRD_LAT-1:0] vld_ff;
   logic [TAG_W:0]     side_ff [CRD_LAT];

   logic signed [31:0] ang_w;
   logic signed [31:0] fold_in;
   logic               neg_in;

   logic signed [35:0] x_ff [CRD_STEPS+1];
   logic signed [35:0] y_ff [CRD_STEPS+1];
   logic signed [35:0] z_ff [CRD_STEPS+1];
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;

   always_comb begin
      ang_w   = 32'(in_angle);
      fold_in = ang_w;
      neg_in  = 1'b0;
      if (ang_w > HALF_PI_Q28) begin
         fold_in = ang_w - PI_Q28;
         neg_in  = 1'b1;
      end else if (ang_w < -HALF_PI_Q28) begin
         fold_in = ang_w + PI_Q28;
         neg_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[CRD_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= {neg_in, in_tag};
      for (int k = 1; k < CRD_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= CRD_GAIN;
      y_ff[0] <= '0;
      z_ff[0] <= 36'(fold_in) <<< 2;
   end

   for (genvar i = 0; i < CRD_STEPS; i++) begin : g_step
      localparam logic signed [35:0] ATAN = 36'(atan_q30(i));
      always_ff @(posedge clock) begin
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ATAN;
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (side_ff[CRD_LAT-2][TAG_W]) begin
         cos_ff <= -clamp_q30(x_ff[CRD_STEPS]);
         sin_ff <= -clamp_q30(y_ff[CRD_STEPS]);
      end else begin
         cos_ff <= clamp_q30(x_ff[CRD_STEPS]);
         sin_ff <= clamp_q30(y_ff[CRD_STEPS]);
      end
   end

   assign out_valid = vld_ff[CRD_LAT-1];
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_tag   = side_ff[CRD_LAT-1][TAG_W-1:0];

endmodule
`default_nettype wire

[hdl/aarm_mtx.sv]
// rotation matrix assembly and saturated translation column
`default_nettype none
module aarm_mtx (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  aarm_pkg::vec3_type     in_unit,
   input  logic                   in_zero,
   input  aarm_pkg::coord_type    in_cos,
   input  aarm_pkg::coord_type    in_sin,
   input  aarm_pkg::vec3_type     in_point,
   output logic                   out_valid,
   output aarm_pkg::coord_type    out_rot [9],
   output aarm_pkg::vec3_type     out_shift
);
   import aarm_pkg::*;

   logic [MTX_LAT-1:0] vld_ff;

   logic signed [35:0] n_c [3];
   logic signed [31:0] p_c [3];

   // stage 1
   logic signed [35:0] uu1_ff, vv1_ff, ww1_ff, uv1_ff, uw1_ff, vw1_ff;
   logic signed [35:0] c1_ff, t1_ff, s1_ff;
   logic signed [35:0] n1_ff [3];
   logic signed [31:0] p1_ff [3];
   logic               z1_ff;
   // stage 2
   logic signed [35:0] uu2_ff, vv2_ff, ww2_ff, uv2_ff, uw2_ff, vw2_ff;
   logic signed [35:0] a0_2_ff, a4_2_ff, a8_2_ff;
   logic signed [35:0] c2_ff, t2_ff, s2_ff;
   logic signed [35:0] n2_ff [3];
   logic signed [31:0] p2_ff [3];
   logic               z2_ff;
   // stage 3
   logic signed [35:0] uu3_ff, vv3_ff, ww3_ff;
   logic signed [35:0] pc0_ff, pc4_ff, pc8_ff, puv_ff, puw_ff, pvw_ff;
   logic signed [35:0] pns_ff [3];
   logic signed [31:0] p3_ff [3];
   logic               z3_ff;
   // stage 4 to 7
   logic signed [35:0] raw_c [9];
   logic signed [31:0] rot4_ff [9];
   logic signed [31:0] rot5_ff [9];
   logic signed [31:0] rot6_ff [9];
   logic signed [31:0] rot7_ff [9];
   logic signed [31:0] p4_ff [3];
   logic signed [31:0] p5_ff [3];
   logic signed [31:0] p6_ff [3];
   logic signed [63:0] prd5_ff [9];
   logic signed [35:0] q6_ff [3];
   logic signed [31:0] sh7_ff [3];

   assign n_c[0] = 36'(in_unit.x);
   assign n_c[1] = 36'(in_unit.y);
   assign n_c[2] = 36'(in_unit.z);
   assign p_c[0] = in_point.x;
   assign p_c[1] = in_point.y;
   assign p_c[2] = in_point.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[MTX_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      uu1_ff <= mul30(n_c[0], n_c[0]);
      vv1_ff <= mul30(n_c[1], n_c[1]);
      ww1_ff <= mul30(n_c[2], n_c[2]);
      uv1_ff <= mul30(n_c[0], n_c[1]);
      uw1_ff <= mul30(n_c[0], n_c[2]);
      vw1_ff <= mul30(n_c[1], n_c[2]);
      c1_ff  <= 36'(in_cos);
      t1_ff  <= ONE_Q30 - 36'(in_cos);
      s1_ff  <= 36'(in_sin);
      n1_ff  <= n_c;
      p1_ff  <= p_c;
      z1_ff  <= in_zero;
   end

   always_ff @(posedge clock) begin
      uu2_ff  <= uu1_ff;
      vv2_ff  <= vv1_ff;
      ww2_ff  <= ww1_ff;
      uv2_ff  <= uv1_ff;
      uw2_ff  <= uw1_ff;
      vw2_ff  <= vw1_ff;
      a0_2_ff <= vv1_ff + ww1_ff;
      a4_2_ff <= uu1_ff + ww1_ff;
      a8_2_ff <= uu1_ff + vv1_ff;
      c2_ff   <= c1_ff;
      t2_ff   <= t1_ff;
      s2_ff   <= s1_ff;
      n2_ff   <= n1_ff;
      p2_ff   <= p1_ff;
      z2_ff   <= z1_ff;
   end

   always_ff @(posedge clock) begin
      uu3_ff <= uu2_ff;
      vv3_ff <= vv2_ff;
      ww3_ff <= ww2_ff;
      pc0_ff <= mul30(a0_2_ff, c2_ff);
      pc4_ff <= mul30(a4_2_ff, c2_ff);
      pc8_ff <= mul30(a8_2_ff, c2_ff);
      puv_ff <= mul30(uv2_ff, t2_ff);
      puw_ff <= mul30(uw2_ff, t2_ff);
      pvw_ff <= mul30(vw2_ff, t2_ff);
      for (int j = 0; j < 3; j++) begin
         pns_ff[j] <= mul30(n2_ff[j], s2_ff);
      end
      p3_ff <= p2_ff;
      z3_ff <= z2_ff;
   end

   always_comb begin
      raw_c[0] = uu3_ff + pc0_ff;
      raw_c[1] = puv_ff - pns_ff[2];
      raw_c[2] = puw_ff + pns_ff[1];
      raw_c[3] = puv_ff + pns_ff[2];
      raw_c[4] = vv3_ff + pc4_ff;
      raw_c[5] = pvw_ff - pns_ff[0];
      raw_c[6] = puw_ff - pns_ff[1];
      raw_c[7] = pvw_ff + pns_ff[0];
      raw_c[8] = ww3_ff + pc8_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         if (z3_ff) begin
            rot4_ff[k] <= (k % 4 == 0) ? 32'(ONE_Q30) : 32'sd0;
         end else begin
            rot4_ff[k] <= clamp_q30(raw_c[k]);
         end
      end
      p4_ff <= p3_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         prd5_ff[k] <= 64'(rot4_ff[k]) * 64'(p4_ff[k % 3]);
      end
      rot5_ff <= rot4_ff;
      p5_ff   <= p4_ff;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         logic signed [65:0] acc;
         acc = 66'(prd5_ff[3*j]) + 66'(prd5_ff[3*j+1]) + 66'(prd5_ff[3*j+2])
               + 66'sd536870912;
         q6_ff[j] <= 36'(acc >>> 30);
      end
      rot6_ff <= rot5_ff;
      p6_ff   <= p5_ff;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         logic signed [36:0] dif;
         dif = 37'(p6_ff[j]) - 37'(q6_ff[j]);
         if (dif > 37'sd2147483647) begin
            sh7_ff[j] <= 32'sh7fffffff;
         end else if (dif < -37'sd2147483648) begin
            sh7_ff[j] <= 32'sh80000000;
         end else begin
            sh7_ff[j] <= 32'(dif);
         end
      end
      rot7_ff <= rot6_ff;
   end

   assign out_valid   = vld_ff[MTX_LAT-1];
   assign out_rot     = rot7_ff;
   assign out_shift.x = sh7_ff[0];
   assign out_shift.y = sh7_ff[1];
   assign out_shift.z = sh7_ff[2];

endmodule
`default_nettype wire

[hdl/axis_angle_rotation_matrix.sv]
// an accepted start yields its rsp_strobe after passing the normalizer, cordic and matrix pipelines in turn
// throughput: one transaction per cycle; busy stays low and start is taken every cycle
// latency is set by the 32-step square root, the 31-step dividers and the 30-step cordic
// results are shown for exactly one cycle on rsp_strobe; the receiver cannot stall
// synchronous active-high reset clears all valid bits; payload registers are not reset
`default_nettype none
module axis_angle_rotation_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  aarm_pkg::coord_type  req_axis_point_x,
   input  aarm_pkg::coord_type  req_axis_point_y,
   input  aarm_pkg::coord_type  req_axis_point_z,
   input  aarm_pkg::coord_type  req_axis_dir_x,
   input  aarm_pkg::coord_type  req_axis_dir_y,
   input  aarm_pkg::coord_type  req_axis_dir_z,
   input  aarm_pkg::angle_type  req_turn_angle,
   output logic                 rsp_strobe,
   output aarm_pkg::coord_type  rsp_rot_00,
   output aarm_pkg::coord_type  rsp_rot_01,
   output aarm_pkg::coord_type  rsp_rot_02,
   output aarm_pkg::coord_type  rsp_rot_10,
   output aarm_pkg::coord_type  rsp_rot_11,
   output aarm_pkg::coord_type  rsp_rot_12,
   output aarm_pkg::coord_type  rsp_rot_20,
   output aarm_pkg::coord_type  rsp_rot_21,
   output aarm_pkg::coord_type  rsp_rot_22,
   output aarm_pkg::coord_type  rsp_shift_x,
   output aarm_pkg::coord_type  rsp_shift_y,
   output aarm_pkg::coord_type  rsp_shift_z
);
   import aarm_pkg::*;

   // tag widths: angle and point ride with the normalizer, unit/zero/point with the cordic
   localparam int NTAG_W = 31 + 96;
   localparam int CTAG_W = 96 + 1 + 96;

   logic        take;
   vec3_type    dir_w;
   vec3_type    pnt_w;

   logic              nrm_vld;
   vec3_type          nrm_unit;
   logic              nrm_zero;
   logic [NTAG_W-1:0] nrm_tag;

   logic              crd_vld;
   coord_type         crd_cos;
   coord_type         crd_sin;
   logic [CTAG_W-1:0] crd_tag;

   vec3_type          m_unit;
   vec3_type          m_point;
   logic              m_zero;

   logic              mtx_vld;
   coord_type         mtx_rot [9];
   vec3_type          mtx_shift;

   // the pipeline never backs up, so every start is a transaction
   assign busy = 1'b0;
   assign take = start && !busy;

   assign dir_w = '{x: req_axis_dir_x, y: req_axis_dir_y, z: req_axis_dir_z};
   assign pnt_w = '{x: req_axis_point_x, y: req_axis_point_y, z: req_axis_point_z};

   // unit direction via isqrt and long division
   aarm_norm #(
      .TAG_W (NTAG_W)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_dir    (dir_w),
      .in_tag    ({req_turn_angle, pnt_w}),
      .out_valid (nrm_vld),
      .out_unit  (nrm_unit),
      .out_zero  (nrm_zero),
      .out_tag   (nrm_tag)
   );

   // cosine and sine of the delayed angle
   aarm_cordic #(
      .TAG_W (CTAG_W)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (nrm_vld),
      .in_angle  (nrm_tag[NTAG_W-1:96]),
      .in_tag    ({nrm_unit, nrm_zero, nrm_tag[95:0]}),
      .out_valid (crd_vld),
      .out_cos   (crd_cos),
      .out_sin   (crd_sin),
      .out_tag   (crd_tag)
   );

   assign m_unit  = crd_tag[CTAG_W-1:97];
   assign m_zero  = crd_tag[96];
   assign m_point = crd_tag[95:0];

   // matrix entries and translation, last stage doubles as output register
   aarm_mtx u_mtx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (crd_vld),
      .in_unit   (m_unit),
      .in_zero   (m_zero),
      .in_cos    (crd_cos),
      .in_sin    (crd_sin),
      .in_point  (m_point),
      .out_valid (mtx_vld),
      .out_rot   (mtx_rot),
      .out_shift (mtx_shift)
   );

   assign rsp_strobe  = mtx_vld;
   assign rsp_rot_00  = mtx_rot[0];
   assign rsp_rot_01  = mtx_rot[1];
   assign rsp_rot_02  = mtx_rot[2];
   assign rsp_rot_10  = mtx_rot[3];
   assign rsp_rot_11  = mtx_rot[4];
   assign rsp_rot_12  = mtx_rot[5];
   assign rsp_rot_20  = mtx_rot[6];
   assign rsp_rot_21  = mtx_rot[7];
   assign rsp_rot_22  = mtx_rot[8];
   assign rsp_shift_x = mtx_shift.x;
   assign rsp_shift_y = mtx_shift.y;
   assign rsp_shift_z = mtx_shift.z;

endmodule
`default_nettype wire

[hdl/aarm_chk.sv]
// port-level checker for the rotation block and its bind
`default_nettype none
module aarm_chk (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input aarm_pkg::coord_type req_axis_dir_x,
   input aarm_pkg::coord_type req_axis_dir_y,
   input aarm_pkg::coord_type req_axis_dir_z,
   input logic                rsp_strobe,
   input aarm_pkg::coord_type rsp_rot_00,
   input aarm_pkg::coord_type rsp_rot_01,
   input aarm_pkg::coord_type rsp_rot_02,
   input aarm_pkg::coord_type rsp_rot_10,
   input aarm_pkg::coord_type rsp_rot_11,
   input aarm_pkg::coord_type rsp_rot_12,
   input aarm_pkg::coord_type rsp_rot_20,
   input aarm_pkg::coord_type rsp_rot_21,
   input aarm_pkg::coord_type rsp_rot_22,
   input aarm_pkg::coord_type rsp_shift_x,
   input aarm_pkg::coord_type rsp_shift_y,
   input aarm_pkg::coord_type rsp_shift_z
);
   import aarm_pkg::*;

   function automatic logic in_rng(input logic signed [31:0] v);
      return (v <= 32'sd1073741824) && (v >= -32'sd1073741824);
   endfunction

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, TOTAL_LAT))
      else $error("result without a matching transaction");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##TOTAL_LAT rsp_strobe)
      else $error("transaction lost");

   a_identity: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_axis_dir_x == 0 && req_axis_dir_y == 0 && req_axis_dir_z == 0)
      |-> ##TOTAL_LAT (rsp_rot_00 == 32'sd1073741824 && rsp_rot_11 == 32'sd1073741824
         && rsp_rot_22 == 32'sd1073741824 && rsp_rot_01 == 0 && rsp_rot_12 == 0
         && rsp_shift_x == 0 && rsp_shift_y == 0 && rsp_shift_z == 0))
      else $error("zero direction did not give identity");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (in_rng(rsp_rot_00) && in_rng(rsp_rot_01) && in_rng(rsp_rot_02)
         && in_rng(rsp_rot_10) && in_rng(rsp_rot_11) && in_rng(rsp_rot_12)
         && in_rng(rsp_rot_20) && in_rng(rsp_rot_21) && in_rng(rsp_rot_22)))
      else $error("rotation entry out of range");

endmodule

bind axis_angle_rotation_matrix aarm_chk u_aarm_chk (.*);
`default_nettype wire
